/* src/bmf_pkg.sv */
// Shared types, constants and the majority function of the 3x3 binary majority filter.
package bmf_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int SIZE_W = 12;
	localparam logic [SIZE_W-1:0] IMAGE_SIZE_RESET = 12'd2048;
	localparam int QDEPTH = 2;
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int HOOD_W = 9;
	localparam logic [3:0] MAJORITY_MIN = 4'd5;

	// One classified neighborhood waiting for the majority decision.
	typedef struct packed {
		logic [HOOD_W-1:0] hood;
		logic              row_end;
		logic              frame_end;
	} item_t;

	function automatic logic majority(input logic [HOOD_W-1:0] hood);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < HOOD_W; i++) begin
			n = n + {3'd0, hood[i]};
		end
		return n >= MAJORITY_MIN;
	endfunction

endpackage

/* src/bmf_front.sv */
// Front end: raster counters, line stores and window; builds one neighborhood item per interior pixel.
module bmf_front
	import bmf_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              pixel,
	input  logic              cfg_valid,
	input  logic [SIZE_W-1:0] image_size,
	input  logic              q_full,
	output logic              push,
	output item_t             push_item
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RST_SIZE = (int'(IMAGE_SIZE_RESET) > MAX_WIDTH) ? MAX_WIDTH :
		((int'(IMAGE_SIZE_RESET) < 3) ? 3 : int'(IMAGE_SIZE_RESET));
	localparam logic [CW-1:0] RST_LAST = CW'(RST_SIZE - 1);

	logic [CW-1:0] last_q;
	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;
	logic [5:0]    win_q;
	logic          stale_q;
	logic [1:0]    rd_q;
	logic [1:0]    line_mem [MAX_WIDTH];

	logic [CW-1:0] new_last;
	logic [SIZE_W:0] sz;
	logic          last_col;
	logic          last_row;
	logic [CW-1:0] c_eff;
	logic [CW-1:0] c_next;
	logic [CW-1:0] rd_addr;
	logic [2:0]    col;
	logic          fire;

	always_comb begin
		sz = {1'b0, image_size};
		if (sz < (SIZE_W+1)'(3)) begin
			sz = (SIZE_W+1)'(3);
		end else if (sz > (SIZE_W+1)'(MAX_WIDTH)) begin
			sz = (SIZE_W+1)'(MAX_WIDTH);
		end
		new_last = CW'(sz - (SIZE_W+1)'(1));
	end

	assign last_col = col_q >= last_q;
	assign last_row = row_q >= last_q;
	assign c_eff    = last_col ? last_q : col_q;
	assign c_next   = last_col ? '0 : c_eff + CW'(1);

	// The next pixel's line store entry is fetched while this one is taken.
	assign fire     = in_valid && in_ready;
	assign rd_addr  = fire ? c_next : c_eff;
	assign in_ready = !stale_q && !q_full;

	// Bit 0 is the top row, bit 1 the middle, bit 2 the bottom.
	assign col = {pixel, rd_q[0], rd_q[1]};

	assign push                = fire && (row_q >= CW'(2)) && (c_eff >= CW'(2));
	assign push_item.hood      = {win_q, col};
	assign push_item.row_end   = last_col;
	assign push_item.frame_end = last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= RST_LAST;
			col_q   <= '0;
			row_q   <= '0;
			win_q   <= '0;
			stale_q <= 1'b0;
		end else begin
			// A new size changes the fetch address, so input is held off while the entry is fetched again.
			stale_q <= cfg_valid;
			if (cfg_valid) begin
				last_q <= new_last;
			end
			if (fire) begin
				win_q <= {win_q[2:0], col};
				col_q <= c_next;
				if (last_col) begin
					row_q <= last_row ? '0 : row_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			line_mem[c_eff] <= {rd_q[0], pixel};
		end
		rd_q <= line_mem[rd_addr];
	end

endmodule

/* src/bmf_queue.sv */
// Short queue of neighborhood items between the front and back ends.
module bmf_queue
	import bmf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  item_t             push_item,
	input  logic              pop,
	output logic              q_valid,
	output logic              q_full,
	output item_t             q_item,
	output logic [QCNT_W-1:0] q_count
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	item_t             slot_q [QDEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_valid = cnt_q != '0;
	assign q_full  = cnt_q == QCNT_W'(QDEPTH);
	assign q_item  = slot_q[rd_q];
	assign q_count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

endmodule

/* src/bmf_back.sv */
// Back end: majority decision over the nine pixels and the output register.
module bmf_back
	import bmf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_valid,
	input  item_t q_item,
	output logic  pop,
	output logic  out_valid,
	input  logic  out_ready,
	output logic  filtered_pixel,
	output logic  row_end,
	output logic  frame_end
);

	logic out_valid_q;
	logic filtered_q;
	logic row_end_q;
	logic frame_end_q;

	assign pop = q_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			filtered_q  <= majority(q_item.hood);
			row_end_q   <= q_item.row_end;
			frame_end_q <= q_item.frame_end;
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_pixel = filtered_q;
	assign row_end        = row_end_q;
	assign frame_end      = frame_end_q;

endmodule

/* src/binary_majority_filter_3x3.sv */
// Top level of the 3x3 binary majority filter: front end, item queue and back end.
// Pixels of a square image enter in raster order at one per clock while in_ready is
// high; each interior pixel yields one result one row and one column later, with
// row_end on the last result of a row and frame_end on the last of the frame. A result
// reaches the output register through the item queue once the pixel that completes
// its window is taken. The rate is set by the line store, a single memory holding
// both previous rows, which is read for the next pixel while the current one is
// written back. After an image_size write the input is held off while the line store
// entry is fetched again. The line stores start undefined and need no clearing pass.
module binary_majority_filter_3x3
	import bmf_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              pixel,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] image_size,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              filtered_pixel,
	output logic              row_end,
	output logic              frame_end
);

	logic              push;
	item_t             push_item;
	logic              pop;
	logic              q_valid;
	logic              q_full;
	item_t             q_item;
	logic [QCNT_W-1:0] q_count;

	assign cfg_ready = 1'b1;

	bmf_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel     (pixel),
		.cfg_valid (cfg_valid && cfg_ready),
		.image_size(image_size),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	bmf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_full   (q_full),
		.q_item   (q_item),
		.q_count  (q_count)
	);

	bmf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.filtered_pixel(filtered_pixel),
		.row_end       (row_end),
		.frame_end     (frame_end)
	);

	// The queue never holds more items than it has slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QDEPTH))
		else $error("item queue overflow");

	// No pixel is taken in the cycle after a size write.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !(in_valid && in_ready))
		else $error("pixel taken with a stale line store fetch");

	// The last result of a frame is also the last of its row.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> row_end)
		else $error("frame_end without row_end");

	// An item leaves the queue only when it holds one.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_count != '0)
		else $error("pop from an empty item queue");

endmodule
